[rtl/conv2d_pkg.sv]
`default_nettype none

package conv2d_pkg;

	// Command codes of a request beat.
	localparam logic [1:0] CMD_LOAD_KERNEL = 2'd0;
	localparam logic [1:0] CMD_LOAD_IMAGE  = 2'd1;
	localparam logic [1:0] CMD_COMPUTE     = 2'd2;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd0;
	localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_KERNEL_WIDTH   = 3'd2;
	localparam logic [2:0] REG_KERNEL_HEIGHT  = 3'd3;
	localparam logic [2:0] REG_FRACTION_SHIFT = 3'd4;

	// Signed width of a tap position: column plus kernel offset minus half size.
	localparam int POS_W = 8;

	typedef struct packed {
		logic [1:0]         command;
		logic [5:0]         column;
		logic [5:0]         row;
		logic signed [15:0] value;
	} req_item_t;

	typedef struct packed {
		logic signed [15:0] pixel;
		logic               saturated;
	} rsp_item_t;

endpackage

`default_nettype wire

[rtl/conv2d_ram.sv]
`default_nettype none

module conv2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/conv2d_zero_padded.sv]
`default_nettype none

// Channel   Direction  Handshake          Beat
// req       in         req_valid/stall    command, column, row, value
// rsp       out        rsp_valid/stall    pixel, saturated
// apb       in         psel/penable       image and kernel size, fraction shift
//
// A load writes its store and leaves req free. A compute walks each tap through the one
// shared multiplier, then passes the drain, a rounding add, a shift/saturate step and the
// hand-off. An empty kernel skips scan and drain; a compute outside the image goes straight
// to the hand-off with a zero result. req_stall is high while a compute is in flight.
// The result waits in the output register, so the next beat is taken while rsp is stalled.
// Reset restores the size and shift registers and clears the control and output state.

module conv2d_zero_padded
	import conv2d_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int MAX_KERNEL = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire req_item_t   req,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output rsp_item_t        rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int IMG_DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int KER_DEPTH = MAX_KERNEL * MAX_KERNEL;
	localparam int IMG_AW = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
	localparam int KER_AW = (KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 1;
	localparam int SUM_W = 33 + ((KER_DEPTH > 1) ? $clog2(KER_DEPTH) : 0);

	localparam logic signed [SUM_W-1:0] PIX_MAX = SUM_W'(32767);
	localparam logic signed [SUM_W-1:0] PIX_MIN = ~PIX_MAX;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_ROUND,
		ST_SAT,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [6:0] cfg_iw_q;
	logic [6:0] cfg_ih_q;
	logic [3:0] cfg_kw_q;
	logic [3:0] cfg_kh_q;
	logic [3:0] cfg_shift_q;

	logic [6:0] iw_eff;
	logic [6:0] ih_eff;
	logic [3:0] kw_eff;
	logic [3:0] kh_eff;

	logic [5:0] col_q;
	logic [5:0] row_q;
	logic [3:0] l_q;
	logic [3:0] k_q;
	logic       drain_q;
	logic       ok_s1;
	logic       ok_s2;
	logic signed [31:0] prod_s2;
	logic signed [SUM_W-1:0] sum_q;
	rsp_item_t  res_q;
	rsp_item_t  rsp_q;
	logic       rsp_valid_q;

	logic req_accept;
	logic start_compute;
	logic outside;
	logic kernel_empty;
	logic ker_we;
	logic img_we;
	logic [KER_AW-1:0] ker_waddr;
	logic [IMG_AW-1:0] img_waddr;
	logic [KER_AW-1:0] ker_raddr;
	logic [IMG_AW-1:0] img_raddr;
	logic [15:0] ker_rdata;
	logic [15:0] img_rdata;
	logic signed [POS_W-1:0] tap_col;
	logic signed [POS_W-1:0] tap_row;
	logic tap_ok;
	logic [16:0] one_shift;
	logic signed [SUM_W-1:0] shifted;
	logic out_free;
	logic cfg_write;

	// Size registers above the store dimensions act as the maximum.
	assign iw_eff = (int'(cfg_iw_q) > MAX_WIDTH)  ? 7'(MAX_WIDTH)  : cfg_iw_q;
	assign ih_eff = (int'(cfg_ih_q) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : cfg_ih_q;
	assign kw_eff = (int'(cfg_kw_q) > MAX_KERNEL) ? 4'(MAX_KERNEL) : cfg_kw_q;
	assign kh_eff = (int'(cfg_kh_q) > MAX_KERNEL) ? 4'(MAX_KERNEL) : cfg_kh_q;

	// Configuration port.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_iw_q    <= 7'd64;
			cfg_ih_q    <= 7'd64;
			cfg_kw_q    <= 4'd3;
			cfg_kh_q    <= 4'd3;
			cfg_shift_q <= 4'd13;
		end else if (cfg_write) begin
			unique case (paddr[4:2])
				REG_IMAGE_WIDTH:    cfg_iw_q    <= pwdata[6:0];
				REG_IMAGE_HEIGHT:   cfg_ih_q    <= pwdata[6:0];
				REG_KERNEL_WIDTH:   cfg_kw_q    <= pwdata[3:0];
				REG_KERNEL_HEIGHT:  cfg_kh_q    <= pwdata[3:0];
				REG_FRACTION_SHIFT: cfg_shift_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_IMAGE_WIDTH:    prdata = 32'(cfg_iw_q);
			REG_IMAGE_HEIGHT:   prdata = 32'(cfg_ih_q);
			REG_KERNEL_WIDTH:   prdata = 32'(cfg_kw_q);
			REG_KERNEL_HEIGHT:  prdata = 32'(cfg_kh_q);
			REG_FRACTION_SHIFT: prdata = 32'(cfg_shift_q);
			default:            prdata = 32'd0;
		endcase
	end

	// Request decode.
	assign req_stall     = (state_q != ST_IDLE);
	assign req_accept    = req_valid && !req_stall;
	assign outside       = ({1'b0, req.column} >= iw_eff) || ({1'b0, req.row} >= ih_eff);
	assign kernel_empty  = (kw_eff == 4'd0) || (kh_eff == 4'd0);
	assign start_compute = req_accept && (req.command == CMD_COMPUTE) && !outside;

	assign ker_we = req_accept && (req.command == CMD_LOAD_KERNEL) &&
		(req.column < {2'b0, kw_eff}) && (req.row < {2'b0, kh_eff});
	assign img_we = req_accept && (req.command == CMD_LOAD_IMAGE) &&
		({1'b0, req.column} < iw_eff) && ({1'b0, req.row} < ih_eff);
	assign ker_waddr = KER_AW'(int'(req.row) * MAX_KERNEL + int'(req.column));
	assign img_waddr = IMG_AW'(int'(req.row) * MAX_WIDTH + int'(req.column));

	// Tap position of the current kernel entry, centered at half the kernel size.
	assign tap_col = POS_W'(col_q) + POS_W'(l_q) - POS_W'(kw_eff[3:1]);
	assign tap_row = POS_W'(row_q) + POS_W'(k_q) - POS_W'(kh_eff[3:1]);
	assign tap_ok  = (state_q == ST_SCAN) &&
		!tap_col[POS_W-1] && (tap_col[6:0] < iw_eff) &&
		!tap_row[POS_W-1] && (tap_row[6:0] < ih_eff);
	assign ker_raddr = KER_AW'(int'(k_q) * MAX_KERNEL + int'(l_q));
	assign img_raddr = IMG_AW'(int'(tap_row[6:0]) * MAX_WIDTH + int'(tap_col[6:0]));

	conv2d_ram #(
		.WIDTH (16),
		.DEPTH (KER_DEPTH)
	) u_kernel_ram (
		.clk   (clk),
		.we    (ker_we),
		.waddr (ker_waddr),
		.wdata (req.value),
		.raddr (ker_raddr),
		.rdata (ker_rdata)
	);

	conv2d_ram #(
		.WIDTH (16),
		.DEPTH (IMG_DEPTH)
	) u_image_ram (
		.clk   (clk),
		.we    (img_we),
		.waddr (img_waddr),
		.wdata (req.value),
		.raddr (img_raddr),
		.rdata (img_rdata)
	);

	// One LSB of the output grid; bits 16:1 give the half LSB, zero when there are no fraction bits.
	assign one_shift = 17'(1) << cfg_shift_q;
	assign shifted   = sum_q >>> cfg_shift_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// Shared multiply-accumulate.
	always_ff @(posedge clk) begin
		prod_s2 <= $signed(img_rdata) * $signed(ker_rdata);
		if (start_compute) begin
			sum_q <= '0;
		end else if (ok_s2) begin
			sum_q <= sum_q + {{(SUM_W-32){prod_s2[31]}}, prod_s2};
		end else if (state_q == ST_ROUND) begin
			sum_q <= sum_q + SUM_W'(one_shift[16:1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			l_q         <= '0;
			k_q         <= '0;
			drain_q     <= 1'b0;
			ok_s1       <= 1'b0;
			ok_s2       <= 1'b0;
			res_q       <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			ok_s1 <= tap_ok;
			ok_s2 <= ok_s1;
			if ((state_q == ST_DONE) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_accept && (req.command == CMD_COMPUTE)) begin
						col_q <= req.column;
						row_q <= req.row;
						l_q   <= '0;
						k_q   <= '0;
						if (outside) begin
							res_q   <= '0;
							state_q <= ST_DONE;
						end else if (kernel_empty) begin
							state_q <= ST_ROUND;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (l_q == kw_eff - 4'd1) begin
						l_q <= '0;
						if (k_q == kh_eff - 4'd1) begin
							drain_q <= 1'b0;
							state_q <= ST_DRAIN;
						end else begin
							k_q <= k_q + 4'd1;
						end
					end else begin
						l_q <= l_q + 4'd1;
					end
				end
				ST_DRAIN: begin
					// The drain covers the product of the last tap, then the last add.
					drain_q <= 1'b1;
					if (drain_q) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					if (shifted > PIX_MAX) begin
						res_q.pixel     <= 16'sh7fff;
						res_q.saturated <= 1'b1;
					end else if (shifted < PIX_MIN) begin
						res_q.pixel     <= -16'sh8000;
						res_q.saturated <= 1'b1;
					end else begin
						res_q.pixel     <= shifted[15:0];
						res_q.saturated <= 1'b0;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						rsp_q   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
